FILE: rtl/conjugate_gradient_direction_update_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the conjugate gradient direction update block
// Shared concurrent-assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONJUGATE_GRADIENT_DIRECTION_UPDATE_TOP_ASSERT_SVH
`define CONJUGATE_GRADIENT_DIRECTION_UPDATE_TOP_ASSERT_SVH

// Same-cycle implication
`define CGDU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CGDU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cgdu_pkg.sv
// ----------------------------------------------------------------------------
// cgdu_pkg
// Shared constants, codes and interface types of the direction update block.
// ----------------------------------------------------------------------------
package cgdu_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CW         = AW + 1;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCALE   = 2'd0;
  localparam logic [1:0] CFG_ITER    = 2'd1;
  localparam logic [1:0] CFG_RESTART = 2'd2;

  // Item and result kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;
  localparam logic RES_BETA  = 1'b0;
  localparam logic RES_DIR   = 1'b1;

  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_DIV
  } fpu_op_t;

  typedef struct packed {
    logic        start;
    fpu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

endpackage

FILE: rtl/cgdu_fpu.sv
// ----------------------------------------------------------------------------
// cgdu_fpu
// Shared IEEE single unit: add, subtract, multiply and bit-serial divide,
// round to nearest even with full subnormal support.
// ----------------------------------------------------------------------------
module cgdu_fpu (
  input  logic              clk,
  input  logic              rst_n,
  input  cgdu_pkg::fpu_req_t req,
  output cgdu_pkg::fpu_rsp_t rsp
);
  import cgdu_pkg::*;

  localparam int DIV_STEPS = 27;
  localparam logic [31:0] DEF_NAN = 32'hFFC0_0000;
  localparam logic [31:0] QBIT    = 32'h0040_0000;

  typedef struct packed {
    logic              s;
    logic              zero;
    logic              inf;
    logic              nan;
    logic signed [11:0] e;
    logic [23:0]       m;
  } unp_t;

  typedef enum logic [2:0] {F_IDLE, F_CALC, F_DIV, F_NORM, F_ROUND} fstate_t;

  // Split a word into sign, lsb exponent and normalized significand
  function automatic unp_t unpack(input logic [31:0] x);
    unp_t               u;
    logic [23:0]        m;
    logic [4:0]         lz;
    logic signed [11:0] e0;
    u.s    = x[31];
    u.zero = (x[30:0] == 31'd0);
    u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    m      = {x[30:23] != 8'd0, x[22:0]};
    lz     = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) lz = 5'(23 - i);
    end
    u.m = m << lz;
    if (x[30:23] == 8'd0) e0 = -12'sd149;
    else e0 = $signed({4'd0, x[30:23]}) - 12'sd150;
    u.e = e0 - $signed({7'd0, lz});
    return u;
  endfunction

  fstate_t            state_r;
  fpu_op_t            op_r;
  unp_t               ua_r, ub_r;
  logic               spec_r;
  logic [31:0]        spec_val_r;
  logic [51:0]        m_r;
  logic signed [11:0] e_r;
  logic               s_r;
  logic [25:0]        rem_r;
  logic [26:0]        q_r;
  logic [4:0]         cnt_r;
  logic               done_r;
  logic [31:0]        res_r;

  // Special operands decided from the raw request
  unp_t        ua_c, ub_c;
  logic        sbe_c, sx_c, spec_c;
  logic [31:0] spec_val_c;

  always_comb begin
    ua_c       = unpack(req.a);
    ub_c       = unpack(req.b);
    sbe_c      = req.b[31] ^ (req.op == FOP_SUB);
    ub_c.s     = sbe_c;
    sx_c       = req.a[31] ^ req.b[31];
    spec_c     = 1'b1;
    spec_val_c = 32'd0;
    unique case (req.op)
      FOP_ADD, FOP_SUB: begin
        priority if (ua_c.nan) spec_val_c = req.a | QBIT;
        else if (ub_c.nan) spec_val_c = req.b | QBIT;
        else if (ua_c.inf && ub_c.inf && (ua_c.s != sbe_c)) spec_val_c = DEF_NAN;
        else if (ua_c.inf) spec_val_c = req.a;
        else if (ub_c.inf) spec_val_c = {sbe_c, req.b[30:0]};
        else if (ua_c.zero && ub_c.zero) spec_val_c = {ua_c.s & sbe_c, 31'd0};
        else if (ua_c.zero) spec_val_c = {sbe_c, req.b[30:0]};
        else if (ub_c.zero) spec_val_c = req.a;
        else spec_c = 1'b0;
      end
      FOP_MUL: begin
        priority if (ua_c.nan) spec_val_c = req.a | QBIT;
        else if (ub_c.nan) spec_val_c = req.b | QBIT;
        else if ((ua_c.inf && ub_c.zero) || (ua_c.zero && ub_c.inf)) spec_val_c = DEF_NAN;
        else if (ua_c.inf || ub_c.inf) spec_val_c = {sx_c, 8'hFF, 23'd0};
        else if (ua_c.zero || ub_c.zero) spec_val_c = {sx_c, 31'd0};
        else spec_c = 1'b0;
      end
      FOP_DIV: begin
        priority if (ua_c.nan) spec_val_c = req.a | QBIT;
        else if (ub_c.nan) spec_val_c = req.b | QBIT;
        else if ((ua_c.inf && ub_c.inf) || (ua_c.zero && ub_c.zero)) spec_val_c = DEF_NAN;
        else if (ua_c.inf || ub_c.zero) spec_val_c = {sx_c, 8'hFF, 23'd0};
        else if (ua_c.zero || ub_c.inf) spec_val_c = {sx_c, 31'd0};
        else spec_c = 1'b0;
      end
      default: spec_c = 1'b1;
    endcase
  end

  // Add alignment and product
  logic               a_big_c;
  unp_t               big_c, sml_c;
  logic signed [11:0] d_c;
  logic [5:0]         dc_c;
  logic [50:0]        bfull_c, bsh_c;
  logic               lost_c;
  logic [51:0]        add_m_c;
  logic [47:0]        prod_c;

  always_comb begin
    a_big_c = ($signed(ua_r.e) > $signed(ub_r.e)) ||
              (($signed(ua_r.e) == $signed(ub_r.e)) && (ua_r.m >= ub_r.m));
    big_c   = a_big_c ? ua_r : ub_r;
    sml_c   = a_big_c ? ub_r : ua_r;
    d_c     = big_c.e - sml_c.e;
    dc_c    = (d_c > 12'sd51) ? 6'd51 : d_c[5:0];
    bfull_c = {sml_c.m, 27'd0};
    bsh_c   = bfull_c >> dc_c;
    lost_c  = (bfull_c & ((51'd1 << dc_c) - 51'd1)) != 51'd0;
    if (big_c.s == sml_c.s)
      add_m_c = {1'b0, big_c.m, 27'd0} + {1'b0, bsh_c[50:1], bsh_c[0] | lost_c};
    else
      add_m_c = {1'b0, big_c.m, 27'd0} - {1'b0, bsh_c[50:1], bsh_c[0] | lost_c};
    prod_c  = ua_r.m * ub_r.m;
  end

  // Divide step
  logic [25:0] rdiff_c;
  assign rdiff_c = rem_r - {2'd0, ub_r.m};

  // Leading-one search over the raw magnitude
  logic [5:0] lz_c;
  always_comb begin
    lz_c = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (m_r[i]) lz_c = 6'(51 - i);
    end
  end

  // Round to nearest even and pack
  logic signed [12:0] t_c, rs13_c;
  logic [5:0]         rs_c;
  logic [51:0]        kept_c, gsh_c;
  logic               guard_c, sticky_c, inc_c;
  logic [24:0]        mr_c;
  logic signed [11:0] lsb_c, bexp_c;
  logic [31:0]        rnd_c;

  always_comb begin
    t_c      = -13'sd149 - $signed({e_r[11], e_r});
    rs13_c   = (t_c > 13'sd28) ? t_c : 13'sd28;
    rs_c     = (rs13_c > 13'sd63) ? 6'd63 : rs13_c[5:0];
    kept_c   = m_r >> rs_c;
    gsh_c    = m_r >> (rs_c - 6'd1);
    guard_c  = gsh_c[0];
    sticky_c = (m_r & ((52'd1 << (rs_c - 6'd1)) - 52'd1)) != 52'd0;
    inc_c    = guard_c & (sticky_c | kept_c[0]);
    mr_c     = kept_c[24:0] + {24'd0, inc_c};
    lsb_c    = e_r + $signed({6'd0, rs_c});
    bexp_c   = lsb_c + 12'sd150 + $signed({11'd0, mr_c[24]});
    if (m_r == 52'd0) rnd_c = 32'd0;
    else if (mr_c[24] || mr_c[23]) begin
      if (bexp_c >= 12'sd255) rnd_c = {s_r, 8'hFF, 23'd0};
      else rnd_c = {s_r, bexp_c[7:0], mr_c[22:0]};
    end else rnd_c = {s_r, 8'd0, mr_c[22:0]};
  end

  // Sequence one operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= 5'd0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        F_IDLE: begin
          if (req.start) begin
            op_r       <= req.op;
            ua_r       <= ua_c;
            ub_r       <= ub_c;
            spec_r     <= spec_c;
            spec_val_r <= spec_val_c;
            state_r    <= F_CALC;
          end
        end
        F_CALC: begin
          if (spec_r) begin
            res_r   <= spec_val_r;
            done_r  <= 1'b1;
            state_r <= F_IDLE;
          end else begin
            unique case (op_r)
              FOP_ADD, FOP_SUB: begin
                m_r     <= add_m_c;
                e_r     <= big_c.e - 12'sd27;
                s_r     <= big_c.s;
                state_r <= F_NORM;
              end
              FOP_MUL: begin
                m_r     <= {prod_c, 4'd0};
                e_r     <= ua_r.e + ub_r.e - 12'sd4;
                s_r     <= ua_r.s ^ ub_r.s;
                state_r <= F_NORM;
              end
              FOP_DIV: begin
                rem_r   <= {2'd0, ua_r.m};
                q_r     <= 27'd0;
                cnt_r   <= 5'd0;
                s_r     <= ua_r.s ^ ub_r.s;
                state_r <= F_DIV;
              end
              default: state_r <= F_IDLE;
            endcase
          end
        end
        F_DIV: begin
          if (!rdiff_c[25]) begin
            rem_r <= {rdiff_c[24:0], 1'b0};
            q_r   <= {q_r[25:0], 1'b1};
          end else begin
            rem_r <= {rem_r[24:0], 1'b0};
            q_r   <= {q_r[25:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(DIV_STEPS - 1)) state_r <= F_NORM;
        end
        F_NORM: begin
          if (op_r == FOP_DIV) begin
            m_r <= {q_r, rem_r != 26'd0, 24'd0};
            e_r <= ua_r.e - ub_r.e - 12'sd51;
          end else begin
            m_r <= m_r << lz_c;
            e_r <= e_r - $signed({6'd0, lz_c});
          end
          state_r <= (op_r == FOP_DIV) ? F_NORM : F_ROUND;
          if (op_r == FOP_DIV) op_r <= FOP_MUL;
        end
        F_ROUND: begin
          res_r   <= rnd_c;
          done_r  <= 1'b1;
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

FILE: rtl/conjugate_gradient_direction_update_top.sv
// ----------------------------------------------------------------------------
// conjugate_gradient_direction_update_top
// Scales and stores a gradient grid, forms beta and emits search directions.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per gradient sample (kind 0, last closes the grid)
//           or per direction request (kind 1). in_ready is high only while
//           the sequencer is idle; one item is worked on at a time.
//   out_* : beta report after the closing sample, a direction value per request
//           inside the grid. A finished result sits in the output register;
//           the next item is taken while it waits, and a later result waits for it.
//   cfg_* : register writes (scale, iteration, restart), always ready.
// Arithmetic: every float operation runs through one shared unit. A sample is
//   scaled, and with the update enabled also runs a subtract, two products and
//   two sums; beta adds a divide; a request with the update enabled runs a
//   multiply and an add.
// Reset: clears registers to their reset values and the previous gradient
//   to zero through a fill mark, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module conjugate_gradient_direction_update_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_gradient_bits,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [31:0] out_value_bits,
  output logic        out_final_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cgdu_pkg::*;
  `include "conjugate_gradient_direction_update_top_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_L_SCALE, S_L_SUB, S_L_PN, S_L_PD, S_L_NUM, S_L_DEN,
    S_L_CLOSE, S_L_DIV, S_E_READ, S_E_MUL, S_E_ADD, S_OUT
  } state_t;

  state_t      state_r;
  logic        issued_r;
  logic [31:0] scale_r;
  logic [15:0] iter_r, restart_r;
  logic        last_r;
  logic [31:0] raw_r;
  logic [CW-1:0] load_cnt_r, emit_ptr_r, grid_r, fill_r;
  logic [31:0] num_r, den_r, beta_r;
  logic [31:0] g_r, o_r, d_r, pn_r, pd_r;
  logic        o_vld_r;
  logic        res_kind_r, res_final_r;
  logic [31:0] res_val_r;
  logic        out_valid_r, out_kind_r, out_final_r;
  logic [31:0] out_val_r;

  logic [31:0] scaled_mem [MAX_POINTS];
  logic [31:0] prev_mem   [MAX_POINTS];
  logic [31:0] scaled_rd_r, prev_rd_r;

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  cgdu_fpu u_fpu (
    .clk (clk),
    .rst_n (rst_n),
    .req (fpu_req),
    .rsp (fpu_rsp)
  );

  // Update enable from iteration and restart point
  logic signed [16:0] diff_c;
  logic               en_c;
  assign diff_c = $signed({1'b0, iter_r}) - $signed({1'b0, restart_r});
  assign en_c   = (iter_r > 16'd1) && !diff_c[16] && (diff_c != 17'sd0) &&
                  ((iter_r == 16'd2) || (diff_c[15:1] != 15'd0));

  logic accept_c;
  assign in_ready  = (state_r == S_IDLE);
  assign accept_c  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Read address chosen at accept
  logic [AW-1:0] rd_addr_c;
  logic [CW-1:0] rd_ptr_c;
  assign rd_ptr_c  = (in_kind == KIND_EMIT) ? emit_ptr_r : load_cnt_r;
  assign rd_addr_c = rd_ptr_c[AW-1:0];

  // Drive the shared unit per state
  logic fpu_state_c;
  always_comb begin
    fpu_req.op  = FOP_MUL;
    fpu_req.a   = scale_r;
    fpu_req.b   = raw_r;
    fpu_state_c = 1'b1;
    unique case (state_r)
      S_L_SCALE: begin fpu_req.op = FOP_MUL; fpu_req.a = scale_r; fpu_req.b = raw_r; end
      S_L_SUB:   begin fpu_req.op = FOP_SUB; fpu_req.a = g_r;     fpu_req.b = o_r;   end
      S_L_PN:    begin fpu_req.op = FOP_MUL; fpu_req.a = g_r;     fpu_req.b = d_r;   end
      S_L_PD:    begin fpu_req.op = FOP_MUL; fpu_req.a = o_r;     fpu_req.b = o_r;   end
      S_L_NUM:   begin fpu_req.op = FOP_ADD; fpu_req.a = num_r;   fpu_req.b = pn_r;  end
      S_L_DEN:   begin fpu_req.op = FOP_ADD; fpu_req.a = den_r;   fpu_req.b = pd_r;  end
      S_L_DIV:   begin fpu_req.op = FOP_DIV; fpu_req.a = num_r;   fpu_req.b = den_r; end
      S_E_MUL:   begin fpu_req.op = FOP_MUL; fpu_req.a = o_r;     fpu_req.b = beta_r; end
      S_E_ADD:   begin fpu_req.op = FOP_ADD; fpu_req.a = g_r;     fpu_req.b = d_r;   end
      default:   fpu_state_c = 1'b0;
    endcase
    fpu_req.start = fpu_state_c && !issued_r;
  end

  logic step_done_c;
  assign step_done_c = issued_r && fpu_rsp.done;

  // Clamp beta: negative non-NaN values become zero
  logic [31:0] beta_clamp_c;
  logic        res_nan_c;
  assign res_nan_c    = (fpu_rsp.result[30:23] == 8'hFF) && (fpu_rsp.result[22:0] != 23'd0);
  assign beta_clamp_c = (fpu_rsp.result[31] && !res_nan_c && fpu_rsp.result[30:0] != 31'd0)
                        ? 32'd0 : fpu_rsp.result;

  // Memory write controls
  logic          sc_we_c, pv_we_c;
  logic [AW-1:0] ld_addr_c, em_addr_c;
  assign ld_addr_c = load_cnt_r[AW-1:0];
  assign em_addr_c = emit_ptr_r[AW-1:0];
  assign sc_we_c   = (state_r == S_L_SCALE) && step_done_c;
  assign pv_we_c   = (state_r == S_E_READ);

  // Stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (sc_we_c) scaled_mem[ld_addr_c] <= fpu_rsp.result;
    if (pv_we_c) prev_mem[em_addr_c]   <= scaled_rd_r;
    if (accept_c) begin
      scaled_rd_r <= scaled_mem[rd_addr_c];
      prev_rd_r   <= prev_mem[rd_addr_c];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      scale_r     <= SCALE_RESET;
      iter_r      <= 16'd0;
      restart_r   <= 16'd0;
      load_cnt_r  <= '0;
      emit_ptr_r  <= '0;
      grid_r      <= '0;
      fill_r      <= '0;
      num_r       <= 32'd0;
      den_r       <= 32'd0;
      beta_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SCALE:   scale_r   <= cfg_data;
          CFG_ITER:    iter_r    <= cfg_data[15:0];
          CFG_RESTART: restart_r <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (fpu_req.start) issued_r <= 1'b1;
      if (step_done_c) issued_r <= 1'b0;

      // Drop the output once taken, unless a new result replaces it
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept_c) begin
            raw_r   <= in_gradient_bits;
            last_r  <= in_last;
            o_vld_r <= rd_ptr_c < fill_r;
            if (in_kind == KIND_EMIT)
              state_r <= (emit_ptr_r < grid_r) ? S_E_READ : S_IDLE;
            else
              state_r <= (load_cnt_r < CW'(MAX_POINTS)) ? S_L_SCALE : S_L_CLOSE;
          end
        end
        S_L_SCALE: begin
          if (step_done_c) begin
            g_r <= fpu_rsp.result;
            o_r <= o_vld_r ? prev_rd_r : 32'd0;
            if (en_c) state_r <= S_L_SUB;
            else begin
              load_cnt_r <= load_cnt_r + CW'(1);
              state_r    <= S_L_CLOSE;
            end
          end
        end
        S_L_SUB: if (step_done_c) begin d_r  <= fpu_rsp.result; state_r <= S_L_PN;  end
        S_L_PN:  if (step_done_c) begin pn_r <= fpu_rsp.result; state_r <= S_L_PD;  end
        S_L_PD:  if (step_done_c) begin pd_r <= fpu_rsp.result; state_r <= S_L_NUM; end
        S_L_NUM: if (step_done_c) begin num_r <= fpu_rsp.result; state_r <= S_L_DEN; end
        S_L_DEN: begin
          if (step_done_c) begin
            den_r      <= fpu_rsp.result;
            load_cnt_r <= load_cnt_r + CW'(1);
            state_r    <= S_L_CLOSE;
          end
        end
        S_L_CLOSE: begin
          if (!last_r) state_r <= S_IDLE;
          else if (en_c && den_r[30:0] != 31'd0) state_r <= S_L_DIV;
          else begin
            beta_r      <= 32'd0;
            res_val_r   <= 32'd0;
            res_kind_r  <= RES_BETA;
            res_final_r <= 1'b0;
            grid_r      <= load_cnt_r;
            load_cnt_r  <= '0;
            emit_ptr_r  <= '0;
            num_r       <= 32'd0;
            den_r       <= 32'd0;
            state_r     <= S_OUT;
          end
        end
        S_L_DIV: begin
          if (step_done_c) begin
            beta_r      <= beta_clamp_c;
            res_val_r   <= beta_clamp_c;
            res_kind_r  <= RES_BETA;
            res_final_r <= 1'b0;
            grid_r      <= load_cnt_r;
            load_cnt_r  <= '0;
            emit_ptr_r  <= '0;
            num_r       <= 32'd0;
            den_r       <= 32'd0;
            state_r     <= S_OUT;
          end
        end
        S_E_READ: begin
          g_r        <= scaled_rd_r;
          o_r        <= o_vld_r ? prev_rd_r : 32'd0;
          emit_ptr_r <= emit_ptr_r + CW'(1);
          if (emit_ptr_r == fill_r) fill_r <= fill_r + CW'(1);
          res_kind_r  <= RES_DIR;
          res_val_r   <= scaled_rd_r;
          res_final_r <= (emit_ptr_r + CW'(1)) == grid_r;
          state_r     <= en_c ? S_E_MUL : S_OUT;
        end
        S_E_MUL: if (step_done_c) begin d_r <= fpu_rsp.result; state_r <= S_E_ADD; end
        S_E_ADD: begin
          if (step_done_c) begin
            res_val_r <= fpu_rsp.result;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_val_r   <= res_val_r;
            out_final_r <= res_final_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_value_bits  = out_val_r;
  assign out_final_res   = out_final_r;

  `CGDU_ASSERT_NXT(a_one_item,
    accept_c && !((in_kind == KIND_EMIT) && (emit_ptr_r >= grid_r)), !in_ready,
    "item accepted while another in work")
  `CGDU_ASSERT_IMP(a_counts, 1'b1,
    (load_cnt_r <= CW'(MAX_POINTS)) && (fill_r <= CW'(MAX_POINTS)) && (emit_ptr_r <= grid_r),
    "point counter out of range")
  `CGDU_ASSERT_NXT(a_single_issue, fpu_req.start, !fpu_req.start, "shared unit issued twice")
  `CGDU_ASSERT_IMP(a_beta_clamped, beta_r[31],
    (beta_r[30:0] == 31'd0) || ((beta_r[30:23] == 8'hFF) && (beta_r[22:0] != 23'd0)),
    "negative beta kept")

endmodule

FILE: sim/tb_conjugate_gradient_direction_update_top.sv
// ----------------------------------------------------------------------------
// Direction update block testbench
// Drives gradient loads and direction requests through the valid/ready input
// channel and checks every beta report and direction value against a
// single-precision predictor, over several scale and iteration settings.
// ----------------------------------------------------------------------------
module tb_conjugate_gradient_direction_update_top;
  import cgdu_pkg::*;

  localparam int RANDOM_ITEMS = 1300;

  typedef struct packed {
    logic        kind;
    logic [31:0] bits;
    logic        fin;
  } dir_result_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] bits;
    logic        last;
    logic        typed;
    logic [31:0] exp_bits;
    logic        exp_fin;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [31:0] in_gradient_bits;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic        out_result_kind;
  logic [31:0] out_value_bits;
  logic        out_final_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  conjugate_gradient_direction_update_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_gradient_bits (in_gradient_bits),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_value_bits   (out_value_bits),
    .out_final_res    (out_final_res),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Predictor state
  logic [31:0] scale_reg;
  logic [15:0] iter_reg;
  logic [15:0] restart_reg;
  logic [31:0] scaled_mem [MAX_POINTS];
  logic [31:0] prev_mem [MAX_POINTS];
  logic [31:0] num_acc;
  logic [31:0] den_acc;
  logic [31:0] beta_reg;
  int          load_cnt;
  int          emit_ptr;
  int          grid_size;

  dir_result_t pending_results [$];
  int          err_cnt;
  int          items_sent;
  int          beta_seen;
  int          dir_seen;
  int          hold_at;
  bit          hold_done;
  bit          calm;

  stim_row_t directed_rows [12] = '{
    '{KIND_EMIT, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD, 32'h3F80_0000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD, 32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{KIND_LOAD, 32'h7F7F_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{KIND_EMIT, 32'h0000_0000, 1'b0, 1'b1, 32'h3F80_0000, 1'b0},
    '{KIND_EMIT, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0001, 1'b0},
    '{KIND_EMIT, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
    '{KIND_EMIT, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{KIND_EMIT, 32'h0000_0000, 1'b0, 1'b1, 32'h7F7F_FFFF, 1'b1},
    '{KIND_EMIT, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0}
  };

  // Single-precision arithmetic: operate in double, then round once to single
  function automatic real sp_to_real(input logic [31:0] f);
    real r;
    if (f[30:23] == 8'hFF) begin
      return $bitstoreal(f[22:0] != 0 ? 64'h7FF8_0000_0000_0000 :
                         {f[31], 11'h7FF, 52'h0});
    end
    if (f[30:23] == 8'h00) begin
      r = real'(f[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
      return f[31] ? -r : r;
    end
    return $bitstoreal({f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'h0});
  endfunction

  function automatic logic [31:0] real_to_sp(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] mant;
    logic [63:0] low;
    logic [63:0] half;
    logic [32:0] w;
    int          ex;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) begin
      return d[51:0] != 0 ? {d[63], 31'h7FC0_0000} : {d[63], 8'hFF, 23'h0};
    end
    if (d[62:52] == 11'h000) return {d[63], 31'h0};
    ex  = int'(d[62:52]) - 1023 + 127;
    sig = {11'h0, 1'b1, d[51:0]};
    sh  = (ex >= 1) ? 29 : 30 - ex;
    if (sh > 60) return {d[63], 31'h0};
    mant = sig >> sh;
    low  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (ex >= 1) w = (33'(ex) << 23) + 33'(mant[22:0]);
    else w = 33'(mant);
    if (low > half || (low == half && mant[0])) w = w + 33'd1;
    if (w >= 33'h7F80_0000) return {d[63], 8'hFF, 23'h0};
    return {d[63], w[30:0]};
  endfunction

  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    return real_to_sp(sp_to_real(a) + sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_sub(input logic [31:0] a, input logic [31:0] b);
    return real_to_sp(sp_to_real(a) - sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    return real_to_sp(sp_to_real(a) * sp_to_real(b));
  endfunction

  function automatic bit sp_is_nan(input logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] != 0;
  endfunction

  function automatic bit direction_enabled();
    int diff;
    diff = int'(iter_reg) - int'(restart_reg);
    if (iter_reg <= 16'd1 || diff < 1) return 1'b0;
    return iter_reg == 16'd2 || diff >= 2;
  endfunction

  // Advance the predictor by one accepted transaction; return 1 on a result
  function automatic bit predict_direction(input logic kind, input logic [31:0] raw,
                                           input logic last, output dir_result_t res);
    bit          en;
    logic [31:0] g;
    logic [31:0] o;
    logic [31:0] b;
    real         br;
    en = direction_enabled();
    res = '0;
    if (kind == KIND_LOAD) begin
      if (load_cnt < MAX_POINTS) begin
        g = sp_mul(scale_reg, raw);
        scaled_mem[load_cnt] = g;
        if (en) begin
          o = prev_mem[load_cnt];
          num_acc = sp_add(num_acc, sp_mul(g, sp_sub(g, o)));
          den_acc = sp_add(den_acc, sp_mul(o, o));
        end
        load_cnt++;
      end
      if (!last) return 1'b0;
      b = 32'h0;
      if (en && sp_to_real(den_acc) != 0.0)
        b = real_to_sp(sp_to_real(num_acc) / sp_to_real(den_acc));
      br = sp_to_real(b);
      if (br < 0.0) b = 32'h0;
      beta_reg  = b;
      grid_size = load_cnt;
      load_cnt  = 0;
      emit_ptr  = 0;
      num_acc   = 32'h0;
      den_acc   = 32'h0;
      res = '{RES_BETA, beta_reg, 1'b0};
      return 1'b1;
    end
    if (emit_ptr >= grid_size || emit_ptr >= MAX_POINTS) return 1'b0;
    g = scaled_mem[emit_ptr];
    b = en ? sp_add(g, sp_mul(prev_mem[emit_ptr], beta_reg)) : g;
    prev_mem[emit_ptr] = g;
    emit_ptr++;
    res = '{RES_DIR, b, emit_ptr == grid_size};
    return 1'b1;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #30_000_000;
    $display("timeout at %0t", $time);
    $display("DONE: errors detected");
    $finish;
  end

  // Result receiver: random stalls, one long hold-off, one stall-free stretch
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && hold_at > 0 && items_sent >= hold_at) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  // Check each result transaction against the oldest pending expectation
  always @(posedge clk) begin
    dir_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result kind=%0d value=%h final=%0d", $time,
                 out_result_kind, out_value_bits, out_final_res);
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind != want.kind) begin
          err_cnt++;
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind,
                   out_result_kind);
        end
        if (out_value_bits != want.bits &&
            !(sp_is_nan(want.bits) && sp_is_nan(out_value_bits))) begin
          err_cnt++;
          $display("%0t: value_bits expected %h actual %h", $time, want.bits,
                   out_value_bits);
        end
        if (out_final_res != want.fin) begin
          err_cnt++;
          $display("%0t: final_res expected %0d actual %0d", $time, want.fin,
                   out_final_res);
        end
        if (want.kind == RES_BETA) beta_seen++;
        else dir_seen++;
      end
    end
  end

  // Offer one input transaction, sometimes after a random gap, and predict it
  task automatic send_item(input logic kind, input logic [31:0] raw, input logic last,
                           input bit typed, input logic [31:0] t_bits,
                           input logic t_fin);
    dir_result_t res;
    @(negedge clk);
    if (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_gradient_bits <= raw;
    in_last          <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (predict_direction(kind, raw, last, res)) begin
      if (typed) res.bits = t_bits;
      if (typed) res.fin = t_fin;
      pending_results.push_back(res);
    end
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SCALE:   scale_reg = val;
      CFG_ITER:    iter_reg = val[15:0];
      CFG_RESTART: restart_reg = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly moderate magnitudes, sometimes any bit pattern at all
  function automatic logic [31:0] rand_sample();
    if ($urandom_range(99) < 10) return $urandom;
    return {1'($urandom), 8'($urandom_range(115, 135)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7F7F_FFFF;
      3: return 32'h0000_0001;
      4: return $urandom;
      default: return {1'b0, 8'($urandom_range(120, 130)), 23'($urandom)};
    endcase
  endfunction

  initial begin
    int          n;
    int          reqs;
    int          diff;
    int          phases;
    logic [15:0] it;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = KIND_LOAD;
    in_gradient_bits = 32'h0;
    in_last          = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_SCALE;
    cfg_data         = 32'h0;
    err_cnt = 0; items_sent = 0; beta_seen = 0; dir_seen = 0;
    hold_at = 0; hold_done = 1'b0; calm = 1'b0; phases = 0;
    scale_reg = SCALE_RESET; iter_reg = '0; restart_reg = '0;
    num_acc = '0; den_acc = '0; beta_reg = '0;
    load_cnt = 0; emit_ptr = 0; grid_size = 0;
    foreach (prev_mem[i]) prev_mem[i] = '0;
    foreach (scaled_mem[i]) scaled_mem[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows at reset settings: update disabled, unit scale
    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].bits, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].exp_bits,
                directed_rows[i].exp_fin);

    // Random phases of settings, grid loads and direction requests
    n = items_sent;
    hold_at = n + 300;
    while (items_sent < n + RANDOM_ITEMS) begin
      drain_results();
      phases++;
      calm = (phases >= 20 && phases < 26);
      case ($urandom_range(7))
        0: begin it = 16'd2; diff = 1; end
        1: begin it = 16'($urandom_range(0, 3)); diff = $urandom_range(0, 2); end
        2: begin it = 16'hFFFF; diff = $urandom_range(0, 3); end
        3: begin it = 16'($urandom); diff = -int'($urandom_range(1, 100)); end
        default: begin it = 16'($urandom_range(3, 65535)); diff = $urandom_range(2, 3); end
      endcase
      write_reg(CFG_SCALE, phases % 9 == 0 ? SCALE_RESET : rand_scale());
      write_reg(CFG_ITER, {16'h0, it});
      write_reg(CFG_RESTART, {16'h0, 16'(int'(it) - diff)});
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 8)
          send_item(KIND_EMIT, $urandom, 1'($urandom), 1'b0, '0, 1'b0);
        send_item(KIND_LOAD, rand_sample(), i == n - 1, 1'b0, '0, 1'b0);
      end
      reqs = ($urandom_range(99) < 15) ? $urandom_range(0, n) : n + $urandom_range(0, 2);
      for (int i = 0; i < reqs; i++)
        send_item(KIND_EMIT, $urandom, 1'($urandom), 1'b0, '0, 1'b0);
      n = items_sent - (items_sent - n);
      n = items_sent - items_sent + (hold_at - 300);
    end

    drain_results();
    $display("Covered %0d transactions over %0d setting phases, with %0d beta reports",
             items_sent, phases, beta_seen);
    $display("and %0d direction values, including a long receiver hold-off.", dir_seen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cgdu_pkg.sv
rtl/cgdu_fpu.sv
rtl/conjugate_gradient_direction_update_top.sv
sim/tb_conjugate_gradient_direction_update_top.sv
